@@ rtl/utf8_byte_stream_decoder_core_macros.svh @@
// ----------------------------------------------------------------------------
// utf8 decoder assertion macros
// shared concurrent assertion wrappers for the decoder rtl
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define UTF8D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define UTF8D_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ rtl/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8 decoder package
// result types, code point limits and lead byte decoding shared by the rtl
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CP_W   = 21;
    localparam int ACC_W  = 31;

    localparam logic [CP_W-1:0]  REPL_CHAR = 21'h00FFFD;
    localparam logic [ACC_W-1:0] SURR_LO   = 31'h0000D800;
    localparam logic [ACC_W-1:0] SURR_HI   = 31'h0000DFFF;
    localparam logic [ACC_W-1:0] CP_MAX    = 31'h0010FFFF;

    // continuation count of the three-byte form, the only one allowed surrogates
    localparam logic [2:0] FORM_3BYTE = 3'd2;

    // one decoded result
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            run_end;
    } t_result;

    // everything one byte produces
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_dec;

    // outcome of reading a byte as a lead
    typedef struct packed {
        logic            emit;
        logic            rep;
        logic [CP_W-1:0] cp;
        logic [2:0]      cont;
        logic [4:0]      acc;
    } t_lead;

    // continuation count of a lead byte, zero when not a lead
    function automatic logic [2:0] lead_count(input logic [7:0] b);
        logic [2:0] c;
        c = 3'd0;
        if (b[7:5] == 3'b110)        c = 3'd1;
        else if (b[7:4] == 4'b1110)  c = 3'd2;
        else if (b[7:3] == 5'b11110) c = 3'd3;
        else if (b[7:2] == 6'b111110) c = 3'd4;
        else if (b[7:1] == 7'b1111110) c = 3'd5;
        return c;
    endfunction

    // decode a byte where a lead is expected
    function automatic t_lead lead_decode(input logic [7:0] b, input logic [2:0] left);
        t_lead      r;
        logic [2:0] c;
        c = lead_count(b);
        r = '0;
        if (!b[7]) begin
            r.emit = 1'b1;
            r.cp   = {13'd0, b};
        end else if (c == 3'd0 || left <= c) begin
            r.emit = 1'b1;
            r.rep  = 1'b1;
            r.cp   = REPL_CHAR;
        end else begin
            r.cont = c;
            case (c)
                3'd1:    r.acc = b[4:0];
                3'd2:    r.acc = {1'b0, b[3:0]};
                3'd3:    r.acc = {2'b0, b[2:0]};
                3'd4:    r.acc = {3'b0, b[1:0]};
                default: r.acc = {4'b0, b[0]};
            endcase
        end
        return r;
    endfunction

endpackage

@@ rtl/utf8d_decode.sv @@
// ----------------------------------------------------------------------------
// utf8 decoder step
// sequence state and the per-byte decode into zero, one or two results
// ----------------------------------------------------------------------------
module utf8d_decode import utf8d_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_data_byte,
    input  logic [2:0] i_bytes_left,
    input  logic       i_step,
    output t_dec       o_dec
);

    logic [2:0]       r_pend, n_pend;
    logic [2:0]       r_form, n_form;
    logic [ACC_W-1:0] r_acc,  n_acc;

    t_lead            ld;
    logic [ACC_W-1:0] v;
    logic             bad;

    // per-byte decode and next sequence state
    always_comb begin
        ld     = lead_decode(i_data_byte, i_bytes_left);
        v      = {r_acc[ACC_W-7:0], i_data_byte[5:0]};
        bad    = (r_form != FORM_3BYTE && v >= SURR_LO && v <= SURR_HI) || v > CP_MAX;
        n_pend = r_pend;
        n_form = r_form;
        n_acc  = r_acc;
        o_dec  = '0;
        if (r_pend == 3'd0) begin
            // idle: byte is a lead
            if (ld.emit) begin
                o_dec.count = 2'd1;
                o_dec.res0  = '{code_point: ld.cp, replaced: ld.rep, run_end: 1'b1};
            end else begin
                n_pend = ld.cont;
                n_form = ld.cont;
                n_acc  = {{(ACC_W-5){1'b0}}, ld.acc};
            end
        end else if (i_data_byte[7:6] == 2'b10) begin
            // good continuation
            n_pend = r_pend - 3'd1;
            n_acc  = v;
            if (r_pend == 3'd1) begin
                o_dec.count = 2'd1;
                o_dec.res0  = '{code_point: bad ? REPL_CHAR : v[CP_W-1:0],
                                replaced: bad, run_end: 1'b1};
                n_form = 3'd0;
                n_acc  = '0;
            end
        end else begin
            // broken sequence: replace, then read the byte again as a lead
            o_dec.res0 = '{code_point: REPL_CHAR, replaced: 1'b1, run_end: !ld.emit};
            if (ld.emit) begin
                o_dec.count = 2'd2;
                o_dec.res1  = '{code_point: ld.cp, replaced: ld.rep, run_end: 1'b1};
                n_pend      = 3'd0;
                n_form      = 3'd0;
                n_acc       = '0;
            end else begin
                o_dec.count = 2'd1;
                n_pend      = ld.cont;
                n_form      = ld.cont;
                n_acc       = {{(ACC_W-5){1'b0}}, ld.acc};
            end
        end
    end

    // sequence state, advanced once per consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_form <= '0;
            r_acc  <= '0;
        end else if (i_step) begin
            r_pend <= n_pend;
            r_form <= n_form;
            r_acc  <= n_acc;
        end
    end

endmodule

@@ rtl/utf8_byte_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// utf8 byte stream decoder core
// lenient utf-8 to code point decoder, one byte per word in, one code point out
// ----------------------------------------------------------------------------
// Takes one byte per cycle while s_axis_tready is high: a word is registered,
// decoded against the open sequence from that register, and its results go to
// a two-entry output queue. Most bytes give zero or one result, so the stream
// runs at one byte per clock while results drain. A byte that breaks an open
// sequence and is itself a complete character gives two results; the single
// output port drains one result per cycle, so such a byte waits in the input
// register while the queue holds a result that does not leave in that cycle.
// A word passes the input register, its results the output queue. Replacement
// results carry 0xFFFD with tuser set; tlast marks the last result of a byte.
`include "utf8_byte_stream_decoder_core_macros.svh"

module utf8_byte_stream_decoder_core import utf8d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [10:8] bytes_left
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point
    output logic        m_axis_tlast,   // run_end
    output logic        m_axis_tuser    // replaced
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_byte, n_byte;
    logic [2:0] r_left, n_left;

    t_result    r_q [2];
    t_result    n_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] cnt_ap;
    logic       pop;
    logic       consume;
    t_dec       dec;

    utf8d_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data_byte  (r_byte),
        .i_bytes_left (r_left),
        .i_step       (consume),
        .o_dec        (dec)
    );

    // handshake and queue room
    always_comb begin
        pop           = m_axis_tvalid && m_axis_tready;
        cnt_ap        = r_cnt - {1'b0, pop};
        consume       = r_in_valid && (({1'b0, cnt_ap} + {1'b0, dec.count}) <= 3'd2);
        s_axis_tready = !r_in_valid || consume;
    end

    // input word register
    always_comb begin
        n_in_valid = r_in_valid;
        n_byte     = r_byte;
        n_left     = r_left;
        if (s_axis_tready) begin
            n_in_valid = s_axis_tvalid;
            n_byte     = s_axis_tdata[7:0];
            n_left     = s_axis_tdata[10:8];
        end
    end

    // output queue: shift on pop, append decoded results
    always_comb begin
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = r_q[1];
        n_cnt  = cnt_ap;
        if (consume && dec.count != 2'd0) begin
            case (cnt_ap)
                2'd0: begin
                    n_q[0] = dec.res0;
                    n_q[1] = dec.res1;
                end
                default: n_q[1] = dec.res0;
            endcase
            n_cnt = cnt_ap + dec.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_cnt      <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_left <= n_left;
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    // result port from the queue head
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {3'b0, r_q[0].code_point};
    assign m_axis_tlast  = r_q[0].run_end;
    assign m_axis_tuser  = r_q[0].replaced;

    `UTF8D_ASSERT(a_cnt_range, r_cnt != 2'd3, "output queue count out of range")
    `UTF8D_ASSERT(a_no_overflow, (r_cnt == 2'd2 && !pop) |-> !(consume && dec.count != 2'd0),
        "result pushed into a full queue")
    `UTF8D_ASSERT(a_repl_value,
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[20:0] == REPL_CHAR,
        "replaced result without replacement character")
    `UTF8D_ASSERT(a_cp_max, m_axis_tvalid |-> m_axis_tdata[20:0] <= 21'h10FFFF,
        "code point above unicode range")
    `UTF8D_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!m_axis_tvalid && s_axis_tready),
        "block not idle after reset")

endmodule
